// File: hdl/oct_pkg.sv
// ----------------------------------------------------------------------------
// oct_pkg
// shared types and constants of the overlapping chunk tiler
// ----------------------------------------------------------------------------
package oct_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MORE = 2'd1,
    ST_FULL    = 2'd2,
    ST_ORDER   = 2'd3
  } status_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int CHUNK_W    = 21;
  localparam int OVL_W      = 20;
  localparam int OVL_OUT_W  = 21;
  localparam int IDX_OUT_W  = 7;
  localparam int LAST_W     = 33;
  localparam int CMD_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP = 2'd1;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 21'd64;
  localparam logic [OVL_W-1:0]   OVL_RESET   = 20'd4;

endpackage

// File: hdl/oct_front.sv
// ----------------------------------------------------------------------------
// oct_front
// accepts input beats, flags reversed segments and packs them as commands
// ----------------------------------------------------------------------------
module oct_front import oct_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int CMD_W     = 3 + 2 * TIME_BITS
) (
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_kind,
  input  logic [TIME_BITS-1:0] in_segment_begin,
  input  logic [TIME_BITS-1:0] in_segment_finish,
  input  logic                 fifo_full,
  output logic                 fifo_push,
  output logic [CMD_W-1:0]     fifo_data
);

  kind_t kind;
  logic  bad;

  assign kind      = kind_t'(in_kind);
  assign bad       = (kind == KIND_APPEND) && (in_segment_finish < in_segment_begin);
  assign in_full   = fifo_full;
  assign fifo_push = in_push && !fifo_full;
  assign fifo_data = {kind, bad, in_segment_begin, in_segment_finish};

endmodule

// File: hdl/oct_cmd_fifo.sv
// ----------------------------------------------------------------------------
// oct_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module oct_cmd_fifo #(
  parameter int DW    = 67,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == NW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/oct_back.sv
// ----------------------------------------------------------------------------
// oct_back
// segment table, tiling sequencer, configuration and result register
// ----------------------------------------------------------------------------
module oct_back import oct_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int TIME_BITS    = 32,
  parameter int CMD_W        = 3 + 2 * TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 cmd_empty,
  input  logic [CMD_W-1:0]     cmd_data,
  output logic                 cmd_pop,
  input  logic                 out_pop,
  output logic                 res_valid,
  output logic [1:0]           res_status,
  output logic [TIME_BITS-1:0] res_chunk_begin,
  output logic [OVL_OUT_W-1:0] res_overlap_now,
  output logic [IDX_OUT_W-1:0] res_segment_index
);

  localparam int TW = TIME_BITS;
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int WW = ((TW > LAST_W) ? TW : LAST_W) + 3;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_LEN, S_TEST, S_DEC} state_t;

  function automatic logic [IDX_OUT_W-1:0] idx_of(input logic [CW-1:0] x);
    logic [CW+IDX_OUT_W-1:0] t;
    t = {{IDX_OUT_W{1'b0}}, x};
    return t[IDX_OUT_W-1:0];
  endfunction

  // segment table
  logic [TW-1:0] seg_starts [MAX_SEGMENTS];
  logic [TW-1:0] seg_ends   [MAX_SEGMENTS];
  logic [TW-1:0] rd_sb_r, rd_se_r;
  logic          mem_we;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       cur_r, cur_nxt;
  logic [LAST_W-1:0]   last_r, last_nxt;
  logic                fresh_r, fresh_nxt;
  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic [OVL_W-1:0]    ovl_r, ovl_nxt;
  logic signed [WW-1:0] step_r, negstep_r;
  logic signed [WW-1:0] start_r, start_nxt;
  logic signed [WW-1:0] nb_r, nb_nxt;
  logic signed [WW-1:0] sem_r, sem_nxt;

  logic                 res_valid_r, res_valid_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [TW-1:0]        res_begin_r, res_begin_nxt;
  logic [OVL_OUT_W-1:0] res_ovl_r, res_ovl_nxt;
  logic [IDX_OUT_W-1:0] res_idx_r, res_idx_nxt;

  kind_t         cmd_kind;
  logic          cmd_bad;
  logic [TW-1:0] cmd_begin, cmd_finish;
  logic          can_take;

  logic signed [WW-1:0] sb_w, se_w, chunk_w, ovl_w, last_w;
  logic signed [WW-1:0] fresh_last, start_calc;
  logic                 len_short, hit_end, pull_back;
  logic [OVL_OUT_W-1:0] pull_ovl;

  assign cmd_kind   = kind_t'(cmd_data[CMD_W-1 -: 2]);
  assign cmd_bad    = cmd_data[2*TW];
  assign cmd_begin  = cmd_data[2*TW-1 -: TW];
  assign cmd_finish = cmd_data[TW-1:0];

  assign can_take = (state_r == S_IDLE) && !cmd_empty && (!res_valid_r || out_pop);
  assign cmd_pop  = can_take;

  assign sb_w    = signed'({{(WW-TW){1'b0}}, rd_sb_r});
  assign se_w    = signed'({{(WW-TW){1'b0}}, rd_se_r});
  assign chunk_w = signed'({{(WW-CHUNK_W){1'b0}}, chunk_r});
  assign ovl_w   = signed'({{(WW-OVL_W){1'b0}}, ovl_r});
  assign last_w  = signed'({{(WW-LAST_W){last_r[LAST_W-1]}}, last_r});

  assign len_short  = (se_w - sb_w) < chunk_w;
  assign fresh_last = sb_w + negstep_r;
  assign start_calc = last_w + step_r;
  assign hit_end    = (start_r == sem_r);
  assign pull_back  = (start_r > nb_r);
  assign pull_ovl   = start_r[OVL_OUT_W-1:0] + {1'b0, ovl_r} - nb_r[OVL_OUT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    fresh_nxt      = fresh_r;
    chunk_nxt      = chunk_r;
    ovl_nxt        = ovl_r;
    start_nxt      = start_r;
    nb_nxt         = nb_r;
    sem_nxt        = sem_r;
    mem_we         = 1'b0;
    res_valid_nxt  = res_valid_r && !out_pop;
    res_status_nxt = res_status_r;
    res_begin_nxt  = res_begin_r;
    res_ovl_nxt    = res_ovl_r;
    res_idx_nxt    = res_idx_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_CHUNK:   chunk_nxt = cfg_data[CHUNK_W-1:0];
        CFG_OVERLAP: ovl_nxt   = cfg_data[OVL_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (can_take) begin
          res_begin_nxt = '0;
          res_ovl_nxt   = '0;
          case (cmd_kind)
            KIND_CLEAR: begin
              count_nxt      = '0;
              cur_nxt        = '0;
              last_nxt       = '0;
              fresh_nxt      = 1'b1;
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_OK;
              res_idx_nxt    = '0;
            end
            KIND_APPEND: begin
              res_valid_nxt = 1'b1;
              res_idx_nxt   = idx_of(count_r);
              if (count_r == CW'(MAX_SEGMENTS)) begin
                res_status_nxt = ST_FULL;
              end else if (cmd_bad) begin
                res_status_nxt = ST_ORDER;
              end else begin
                res_status_nxt = ST_OK;
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            KIND_NEXT: begin
              state_nxt = S_CHECK;
            end
            default: begin
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_OK;
              res_idx_nxt    = '0;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (cur_r >= count_r) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_NO_MORE;
          res_begin_nxt  = '0;
          res_ovl_nxt    = '0;
          res_idx_nxt    = idx_of(cur_r);
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (len_short) begin
          cur_nxt   = cur_r + 1'b1;
          fresh_nxt = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          if (fresh_r) begin
            last_nxt  = fresh_last[LAST_W-1:0];
            fresh_nxt = 1'b0;
          end
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        start_nxt = start_calc;
        nb_nxt    = se_w - chunk_w;
        sem_nxt   = se_w - ovl_w;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (hit_end) begin
          cur_nxt   = cur_r + 1'b1;
          fresh_nxt = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_OK;
          res_idx_nxt    = idx_of(cur_r);
          state_nxt      = S_IDLE;
          if (pull_back) begin
            last_nxt      = nb_r[LAST_W-1:0];
            cur_nxt       = cur_r + 1'b1;
            fresh_nxt     = 1'b1;
            res_begin_nxt = nb_r[TW-1:0];
            res_ovl_nxt   = pull_ovl;
          end else begin
            last_nxt      = start_r[LAST_W-1:0];
            res_begin_nxt = start_r[TW-1:0];
            res_ovl_nxt   = {1'b0, ovl_r};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      last_r      <= '0;
      fresh_r     <= 1'b1;
      chunk_r     <= CHUNK_RESET;
      ovl_r       <= OVL_RESET;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      fresh_r     <= fresh_nxt;
      chunk_r     <= chunk_nxt;
      ovl_r       <= ovl_nxt;
      res_valid_r <= res_valid_nxt;
    end
    step_r       <= chunk_w - ovl_w;
    negstep_r    <= ovl_w - chunk_w;
    start_r      <= start_nxt;
    nb_r         <= nb_nxt;
    sem_r        <= sem_nxt;
    res_status_r <= res_status_nxt;
    res_begin_r  <= res_begin_nxt;
    res_ovl_r    <= res_ovl_nxt;
    res_idx_r    <= res_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_starts[count_r[AW-1:0]] <= cmd_begin;
      seg_ends[count_r[AW-1:0]]   <= cmd_finish;
    end
    rd_sb_r <= seg_starts[cur_r[AW-1:0]];
    rd_se_r <= seg_ends[cur_r[AW-1:0]];
  end

  assign res_valid         = res_valid_r;
  assign res_status        = res_status_r;
  assign res_chunk_begin   = res_begin_r;
  assign res_overlap_now   = res_ovl_r;
  assign res_segment_index = res_idx_r;

endmodule

// File: hdl/overlapping_chunk_tiler.sv
// ----------------------------------------------------------------------------
// overlapping_chunk_tiler
// tiles a table of time segments into fixed-length overlapping chunks
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in       in_push / in_full   kind, segment_begin, segment_finish
//  out      out_pop / out_empty status, chunk_begin, overlap_now, segment_index
//  cfg      cfg_valid/cfg_ready index, data (0 chunk length, 1 overlap length)
//
//  clear, append and no-op beats finish in the cycle after leaving the queue
//  a next beat passes the check, length, test and decide states per segment tiled or
//  used up, check and length per segment shorter than a chunk, and check alone when the table runs out
//  the table is one write and one registered read port per cycle
//  reset is synchronous; the table contents are kept, counts are cleared
//  a two-entry command queue and the result register absorb stalls
// ----------------------------------------------------------------------------
module overlapping_chunk_tiler import oct_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int TIME_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_kind,
  input  logic [TIME_BITS-1:0]  in_segment_begin,
  input  logic [TIME_BITS-1:0]  in_segment_finish,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [1:0]            out_status,
  output logic [TIME_BITS-1:0]  out_chunk_begin,
  output logic [OVL_OUT_W-1:0]  out_overlap_now,
  output logic [IDX_OUT_W-1:0]  out_segment_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMD_W = 3 + 2 * TIME_BITS;

  logic             fifo_full, fifo_push, fifo_empty, fifo_pop;
  logic [CMD_W-1:0] fifo_wdata, fifo_rdata;
  logic             res_valid;

  assign cfg_ready = 1'b1;
  assign out_empty = !res_valid;

  oct_front #(.TIME_BITS(TIME_BITS), .CMD_W(CMD_W)) u_front (
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_segment_begin (in_segment_begin),
    .in_segment_finish(in_segment_finish),
    .fifo_full        (fifo_full),
    .fifo_push        (fifo_push),
    .fifo_data        (fifo_wdata)
  );

  oct_cmd_fifo #(.DW(CMD_W), .DEPTH(CMD_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(fifo_wdata),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .empty    (fifo_empty),
    .pop_data (fifo_rdata)
  );

  oct_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .TIME_BITS(TIME_BITS), .CMD_W(CMD_W)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd_empty        (fifo_empty),
    .cmd_data         (fifo_rdata),
    .cmd_pop          (fifo_pop),
    .out_pop          (out_pop),
    .res_valid        (res_valid),
    .res_status       (out_status),
    .res_chunk_begin  (out_chunk_begin),
    .res_overlap_now  (out_overlap_now),
    .res_segment_index(out_segment_index)
  );

endmodule

// File: hdl/oct_checker.sv
// ----------------------------------------------------------------------------
// oct_checker
// port-level checks of the overlapping chunk tiler
// ----------------------------------------------------------------------------
module oct_checker import oct_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_push,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input logic [1:0]            out_status,
  input logic [TIME_BITS-1:0]  out_chunk_begin,
  input logic [OVL_OUT_W-1:0]  out_overlap_now,
  input logic [IDX_OUT_W-1:0]  out_segment_index
);

  logic [3:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present right after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 4'd0) |-> out_empty)
    else $error("result without an accepted beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
      && $stable(out_chunk_begin) && $stable(out_segment_index)))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != ST_OK)) |->
      (out_chunk_begin == '0 && out_overlap_now == '0))
    else $error("chunk fields set on an error result");

endmodule

bind overlapping_chunk_tiler oct_checker #(.TIME_BITS(TIME_BITS)) u_oct_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_status       (out_status),
  .out_chunk_begin  (out_chunk_begin),
  .out_overlap_now  (out_overlap_now),
  .out_segment_index(out_segment_index)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the overlapping chunk tiler
//
// Input beats go in through the push/full queue and results are drained
// through the empty/pop queue. Each side inserts random gaps. A scoreboard
// keeps its own copy of the segment list, the tiling position and the two
// length registers. It predicts every result and compares it field by field
// in order. A directed opening covers the special cases. Random phases then
// run well-formed clear/append/next sequences under a range of chunk and
// overlap settings, misconfigured ones included, mixed with random noise
// beats.
// ----------------------------------------------------------------------------
module tb_top;
  import oct_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_SEG        = 64;
  localparam int TIME_W         = 32;
  localparam int RANDOM_ITEMS   = 1600;
  localparam int N_SETTINGS     = 9;
  localparam int RANDOM_SETTING = 5;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint TIME_MAX   = 64'hFFFF_FFFF;

  typedef struct packed {
    status_t              status;
    logic [TIME_W-1:0]    chunk_start;
    logic [OVL_OUT_W-1:0] overlap;
    logic [IDX_OUT_W-1:0] seg_idx;
  } tile_result_t;

  class chunk_scoreboard;
    logic [CHUNK_W-1:0] chunk_len;
    logic [OVL_W-1:0]   ovl_len;
    logic [TIME_W-1:0]  seg_lo [MAX_SEG];
    logic [TIME_W-1:0]  seg_hi [MAX_SEG];
    int unsigned        seg_count;
    int unsigned        cur_seg;
    logic [LAST_W-1:0]  last_begin;
    bit                 fresh;
    tile_result_t       expected_q[$];
    int mismatches, n_results, n_chunks, n_pulled, n_skipped, n_no_more, n_full, n_order;

    function new();
      chunk_len  = CHUNK_RESET;
      ovl_len    = OVL_RESET;
      seg_count  = 0;
      cur_seg    = 0;
      last_begin = '0;
      fresh      = 1'b1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHUNK:   chunk_len = data[CHUNK_W-1:0];
        CFG_OVERLAP: ovl_len = data[OVL_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function tile_result_t next_chunk();
      tile_result_t r;
      longint chunk, ovl, lo, hi, probe, nb;
      int unsigned s;
      r = '0;
      chunk = longint'(chunk_len);
      ovl = longint'(ovl_len);
      forever begin
        s = cur_seg;
        if (s >= seg_count) begin
          r.status = ST_NO_MORE;
          r.seg_idx = IDX_OUT_W'(s);
          n_no_more++;
          return r;
        end
        lo = longint'(seg_lo[s]);
        hi = longint'(seg_hi[s]);
        if (hi - lo < chunk) begin
          cur_seg++;
          fresh = 1'b1;
          n_skipped++;
          continue;
        end
        if (fresh) begin
          last_begin = LAST_W'(lo - chunk + ovl);
          fresh = 1'b0;
        end
        probe = longint'($signed(last_begin)) + chunk - ovl;
        // segment used up exactly
        if (probe == hi - ovl) begin
          cur_seg++;
          fresh = 1'b1;
          continue;
        end
        r.seg_idx = IDX_OUT_W'(s);
        n_chunks++;
        // last chunk pulled back to the segment end
        if (probe + chunk > hi) begin
          nb = hi - chunk;
          last_begin = LAST_W'(nb);
          cur_seg++;
          fresh = 1'b1;
          r.chunk_start = TIME_W'(nb);
          r.overlap = OVL_OUT_W'(probe + ovl - nb);
          n_pulled++;
          return r;
        end
        last_begin = LAST_W'(probe);
        r.chunk_start = TIME_W'(probe);
        r.overlap = OVL_OUT_W'(ovl);
        return r;
      end
    endfunction

    function status_t note_input(kind_t k, logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
      tile_result_t r;
      r = '0;
      case (k)
        KIND_CLEAR: begin
          seg_count = 0;
          cur_seg = 0;
          last_begin = '0;
          fresh = 1'b1;
        end
        KIND_APPEND: begin
          r.seg_idx = IDX_OUT_W'(seg_count);
          if (seg_count >= MAX_SEG) begin
            r.status = ST_FULL;
            n_full++;
          end else if (hi < lo) begin
            r.status = ST_ORDER;
            n_order++;
          end else begin
            seg_lo[seg_count] = lo;
            seg_hi[seg_count] = hi;
            seg_count++;
          end
        end
        KIND_NEXT: r = next_chunk();
        default: ;
      endcase
      expected_q.push_back(r);
      return r.status;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(tile_result_t got);
      tile_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, status %0h chunk %0h overlap %0h segment %0h",
                 $time, got.status, got.chunk_start, got.overlap, got.seg_idx);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("chunk_begin", want.chunk_start, got.chunk_start);
      compare_field("overlap_now", want.overlap, got.overlap);
      compare_field("segment_index", want.seg_idx, got.seg_idx);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [1:0]            in_kind = KIND_CLEAR;
  logic [TIME_W-1:0]     in_segment_begin = '0;
  logic [TIME_W-1:0]     in_segment_finish = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [1:0]            out_status;
  logic [TIME_W-1:0]     out_chunk_begin;
  logic [OVL_OUT_W-1:0]  out_overlap_now;
  logic [IDX_OUT_W-1:0]  out_segment_index;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHUNK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chunk_scoreboard sb;
  int items_sent = 0;
  int n_holds = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  logic [CFG_DATA_W-1:0] chunk_set [N_SETTINGS] = '{21'd64, 21'd1, 21'd1048576, 21'd100,
      21'd16, 21'd0, 21'd0, 21'd10, 21'h1F_FFFF};
  logic [CFG_DATA_W-1:0] ovl_set [N_SETTINGS] = '{21'd4, 21'd0, 21'd1048575, 21'd0,
      21'd15, 21'd0, 21'd3, 21'd30, 21'h1F_FFFF};

  overlapping_chunk_tiler #(
    .MAX_SEGMENTS(MAX_SEG),
    .TIME_BITS(TIME_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_kind(in_kind),
    .in_segment_begin(in_segment_begin),
    .in_segment_finish(in_segment_finish),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_status(out_status),
    .out_chunk_begin(out_chunk_begin),
    .out_overlap_now(out_overlap_now),
    .out_segment_index(out_segment_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side
  initial begin
    int gap;
    tile_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
      got.status = status_t'(out_status);
      got.chunk_start = out_chunk_begin;
      got.overlap = out_overlap_now;
      got.seg_idx = out_segment_index;
      sb.check_result(got);
    end
  end

  task automatic configure(input logic [CFG_DATA_W-1:0] chunk, input logic [CFG_DATA_W-1:0] ovl);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 2; i++) begin
      cfg_index <= (i == 0) ? CFG_CHUNK : CFG_OVERLAP;
      cfg_data <= (i == 0) ? chunk : ovl;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.write_reg((i == 0) ? CFG_CHUNK : CFG_OVERLAP, (i == 0) ? chunk : ovl);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_beat(input kind_t k, input logic [TIME_W-1:0] lo,
                           input logic [TIME_W-1:0] hi, output status_t st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= k;
    in_segment_begin <= lo;
    in_segment_finish <= hi;
    do @(posedge clk); while (in_full !== 1'b0);
    st = sb.note_input(k, lo, hi);
    items_sent++;
  endtask

  task automatic append_random(input int n);
    status_t st;
    longint c, step, span, lo, hi;
    int mode;
    c = longint'(sb.chunk_len);
    step = (sb.chunk_len > sb.ovl_len) ? c - longint'(sb.ovl_len)
                                       : longint'($urandom_range(1, 50));
    repeat (n) begin
      mode = $urandom_range(0, 19);
      case (mode)
        0, 1: span = (c == 0) ? 0 : longint'($urandom_range(0, 32'(c - 1)));
        2: span = c;
        3, 4: span = c + step * $urandom_range(1, 4);
        5, 6: span = c + step * $urandom_range(0, 3)
                     + ((step > 1) ? longint'($urandom_range(1, 32'(step - 1))) : 0);
        7: span = 0;
        8: span = c + step * $urandom_range(0, 8) + $urandom_range(0, 3);
        default: span = c + longint'($urandom_range(0, 32'(4 * step)));
      endcase
      if (span > TIME_MAX) span = TIME_MAX;
      case ($urandom_range(0, 9))
        0: lo = 0;
        1: lo = TIME_MAX - span;
        default: lo = longint'($urandom_range(0, 32'(TIME_MAX - span)));
      endcase
      hi = lo + span;
      // reversed segment
      if (mode == 19) begin
        lo = longint'($urandom()) | 1;
        hi = longint'($urandom_range(0, 32'(lo - 1)));
      end
      send_beat(KIND_APPEND, TIME_W'(lo), TIME_W'(hi), st);
    end
  endtask

  task automatic run_scenario();
    status_t st;
    int pick, n_seg, cap, n_req;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 8))
        send_beat(kind_t'($urandom_range(0, 3)), $urandom(), $urandom(), st);
      return;
    end
    if (pick < 95) send_beat(KIND_CLEAR, $urandom(), $urandom(), st);
    if (pick < 80) n_seg = $urandom_range(1, 6);
    else if (pick < 90) n_seg = $urandom_range(62, 66);
    else n_seg = $urandom_range(0, 2);
    append_random(n_seg);
    cap = $urandom_range(4, 40);
    n_req = 0;
    do begin
      send_beat(KIND_NEXT, $urandom(), $urandom(), st);
      n_req++;
    end while (st != ST_NO_MORE && n_req < cap);
    // appending mid-way does not rewind
    if ($urandom_range(0, 2) == 0) begin
      append_random($urandom_range(1, 3));
      repeat ($urandom_range(1, 10)) send_beat(KIND_NEXT, $urandom(), $urandom(), st);
    end
  endtask

  initial begin
    status_t st;
    int directed_n;
    logic [CFG_DATA_W-1:0] chunk, ovl;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    configure(CHUNK_RESET, OVL_RESET);

    send_beat(KIND_NEXT, 32'h0, 32'h0, st);
    send_beat(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, st);
    send_beat(KIND_APPEND, 32'd100, 32'd99, st);
    send_beat(KIND_APPEND, 32'd500, 32'd500, st);
    send_beat(KIND_APPEND, 32'd0, 32'd200, st);
    send_beat(KIND_APPEND, 32'd1000, 32'd1050, st);
    send_beat(KIND_APPEND, 32'd2000, 32'd2124, st);
    send_beat(KIND_APPEND, 32'hFFFF_FF00, 32'hFFFF_FFFF, st);
    repeat (13) send_beat(KIND_NEXT, 32'hFFFF_FFFF, 32'h0, st);
    send_beat(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, st);
    send_beat(KIND_NEXT, 32'h0, 32'h0, st);
    send_beat(KIND_APPEND, 32'h0, 32'hFFFF_FFFF, st);
    send_beat(KIND_NEXT, 32'h0, 32'h0, st);
    directed_n = items_sent;

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain();
      chunk = chunk_set[p];
      ovl = ovl_set[p];
      if (p == RANDOM_SETTING) begin
        chunk = CFG_DATA_W'($urandom_range(2, 5000));
        ovl = CFG_DATA_W'($urandom_range(0, 32'(chunk) - 1));
      end
      configure(chunk, ovl);
      no_idle = (p % 3 == 1);
      if (p == 2 || p == 6) hold_req = 1'b1;
      while (items_sent < directed_n + (p + 1) * RANDOM_ITEMS / N_SETTINGS)
        run_scenario();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats over %0d length settings, %0d results checked",
             items_sent, N_SETTINGS + 1, sb.n_results);
    $display("  %0d chunks, %0d pulled back, %0d short skips, %0d list-end, %0d full, %0d reversed, %0d long stalls",
             sb.n_chunks, sb.n_pulled, sb.n_skipped, sb.n_no_more, sb.n_full, sb.n_order,
             n_holds);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
